[hdl/obpl_pkg.sv]
package obpl_pkg;

    localparam int DEF_MAX_ORDERS = 1024;
    localparam int DEF_MAX_LEVELS = 256;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 32;
    localparam int PRICE_W  = 32;
    localparam int QTY_W    = 32;
    localparam int TOTAL_W  = 48;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ORD_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LVL_FULL  = 3'd4;

    typedef struct packed {
        logic               valid;
        logic               side;
        logic [ID_W-1:0]    ident;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   amount;
    } ord_ent_t;

    typedef struct packed {
        logic               valid;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } lvl_ent_t;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_CLEAR,
        STEP_LOAD,
        STEP_OSCAN,
        STEP_LSTART,
        STEP_LSCAN,
        STEP_ORDW,
        STEP_LEAVE,
        STEP_JOIN,
        STEP_ERR,
        STEP_OUT_LOAD
    } step_t;

    typedef struct packed {
        step_t               step;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              o_hit;
        logic              o_free;
        logic              lo_hit;
        logic              ln_hit;
        logic              lf_ok;
        logic              same_price;
        logic              same_qty;
        logic              lo_le1;
        logic              scan_done;
        logic              clr_done;
        logic              out_free;
    } stat_t;

endpackage

[hdl/obpl_ram.sv]
module obpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/obpl_ctrl.sv]
module obpl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  obpl_pkg::stat_t stat,
    output obpl_pkg::cmd_t  cmd
);

    import obpl_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OSCAN,
        S_OCHK,
        S_LSCAN,
        S_LCHK,
        S_LEAVE,
        S_JOIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.step   = STEP_NONE;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.step = STEP_CLEAR;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.step   = STEP_LOAD;
                    state_next = S_OSCAN;
                end
            end
            S_OSCAN: begin
                cmd.step = STEP_OSCAN;
                if (stat.scan_done) state_next = S_OCHK;
            end
            S_OCHK: begin
                unique case (stat.kind) inside
                    KIND_INSERT: begin
                        if (stat.o_hit) begin
                            cmd.step = STEP_ERR;
                            cmd.code = ST_DUPLICATE;
                            state_next = S_OUT;
                        end else if (!stat.o_free) begin
                            cmd.step = STEP_ERR;
                            cmd.code = ST_ORD_FULL;
                            state_next = S_OUT;
                        end else begin
                            cmd.step = STEP_LSTART;
                            state_next = S_LSCAN;
                        end
                    end
                    KIND_MODIFY, KIND_CANCEL: begin
                        if (!stat.o_hit) begin
                            cmd.step = STEP_ERR;
                            cmd.code = ST_NOT_FOUND;
                            state_next = S_OUT;
                        end else begin
                            cmd.step = STEP_LSTART;
                            state_next = S_LSCAN;
                        end
                    end
                    default: begin
                        // unused kind answers ok with empty level fields
                        cmd.step = STEP_ERR;
                        cmd.code = ST_OK;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_LSCAN: begin
                cmd.step = STEP_LSCAN;
                if (stat.scan_done) state_next = S_LCHK;
            end
            S_LCHK: begin
                unique case (stat.kind)
                    KIND_INSERT: begin
                        if (!(stat.ln_hit || stat.lf_ok)) begin
                            cmd.step = STEP_ERR;
                            cmd.code = ST_LVL_FULL;
                            state_next = S_OUT;
                        end else begin
                            cmd.step = STEP_ORDW;
                            state_next = S_JOIN;
                        end
                    end
                    KIND_CANCEL: begin
                        cmd.step = STEP_ORDW;
                        state_next = stat.lo_hit ? S_LEAVE : S_OUT;
                    end
                    default: begin
                        if (stat.same_price) begin
                            cmd.step = STEP_ORDW;
                            state_next = (stat.lo_hit && !stat.same_qty) ? S_LEAVE : S_OUT;
                        end else if (!stat.ln_hit && !stat.lf_ok &&
                                     !(stat.lo_hit && stat.lo_le1)) begin
                            cmd.step = STEP_ERR;
                            cmd.code = ST_LVL_FULL;
                            state_next = S_OUT;
                        end else begin
                            cmd.step = STEP_ORDW;
                            state_next = stat.lo_hit ? S_LEAVE : S_JOIN;
                        end
                    end
                endcase
            end
            S_LEAVE: begin
                cmd.step = STEP_LEAVE;
                state_next = (stat.kind == KIND_CANCEL) ? S_OUT : S_JOIN;
            end
            S_JOIN: begin
                cmd.step = STEP_JOIN;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.step = STEP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

endmodule

[hdl/obpl_dp.sv]
module obpl_dp #(
    parameter int MAX_ORDERS = obpl_pkg::DEF_MAX_ORDERS,
    parameter int MAX_LEVELS = obpl_pkg::DEF_MAX_LEVELS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  obpl_pkg::cmd_t                 cmd,
    output obpl_pkg::stat_t                stat,
    input  logic [obpl_pkg::KIND_W-1:0]    in_kind,
    input  logic [obpl_pkg::ID_W-1:0]      in_id,
    input  logic                           in_side,
    input  logic [obpl_pkg::PRICE_W-1:0]   in_price,
    input  logic [obpl_pkg::QTY_W-1:0]     in_qty,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [obpl_pkg::STATUS_W-1:0]  out_status,
    output logic [obpl_pkg::PRICE_W-1:0]   out_price,
    output logic [obpl_pkg::TOTAL_W-1:0]   out_total,
    output logic [obpl_pkg::COUNT_W-1:0]   out_orders,
    output logic                           out_removed
);

    import obpl_pkg::*;

    localparam int OAW  = $clog2(MAX_ORDERS);
    localparam int LAW  = $clog2(MAX_LEVELS);
    localparam int MAXN = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;
    localparam int CW   = $clog2(MAXN) + 1;

    function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] a,
                                                   input logic [QTY_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {{(TOTAL_W-QTY_W+1){1'b0}}, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] sub_floor(input logic [TOTAL_W-1:0] a,
                                                     input logic [QTY_W-1:0] b);
        logic [TOTAL_W-1:0] bw;
        bw = {{(TOTAL_W-QTY_W){1'b0}}, b};
        return (a > bw) ? a - bw : '0;
    endfunction

    // operation held for the whole sequence
    logic [KIND_W-1:0]  kind_reg;
    logic [ID_W-1:0]    id_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] ri_reg;
    logic          rv_reg;

    logic               ohit_reg, ofree_ok_reg;
    logic [OAW-1:0]     oidx_reg, ofree_reg;
    logic [PRICE_W-1:0] oprice_reg;
    logic [QTY_W-1:0]   oamt_reg;

    logic               lo_hit_reg, ln_hit_reg, lf_ok_reg;
    logic [LAW-1:0]     lo_idx_reg, ln_idx_reg, lf_idx_reg;
    logic [TOTAL_W-1:0] lo_tot_reg, ln_tot_reg;
    logic [COUNT_W-1:0] lo_cnt_reg, ln_cnt_reg;

    logic [TOTAL_W-1:0] tot_reg;
    logic [COUNT_W-1:0] acc_cnt_reg;
    logic               rem_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [PRICE_W-1:0]  res_price_reg;
    logic [TOTAL_W-1:0]  res_total_reg;
    logic [COUNT_W-1:0]  res_orders_reg;
    logic                res_removed_reg;

    logic                out_vld_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [PRICE_W-1:0]  out_price_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [COUNT_W-1:0]  out_orders_reg;
    logic                out_removed_reg;

    ord_ent_t ord_rd, ord_wd;
    lvl_ent_t lvl_rd, lvl_wd;
    logic     ord_we, lvl_we;
    logic [OAW-1:0] ord_wa;
    logic [LAW-1:0] lvl_wa;

    logic          is_oscan, is_lscan;
    logic [CW-1:0] lim;
    logic          iss, last;
    logic          same_mode;

    logic [TOTAL_W-1:0] leave_tot;
    logic [COUNT_W-1:0] leave_cnt;
    logic               leave_freed;
    logic [TOTAL_W-1:0] base_tot, join_tot;
    logic [COUNT_W-1:0] base_cnt, join_cnt;
    logic [LAW-1:0]     join_idx;
    logic               o_match, o_empty, lo_match, ln_match, l_empty;

    obpl_ram #(.WIDTH($bits(ord_ent_t)), .DEPTH(MAX_ORDERS)) u_ord_ram (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (ord_wa),
        .wdata (ord_wd),
        .raddr (cnt_reg[OAW-1:0]),
        .rdata (ord_rd)
    );

    obpl_ram #(.WIDTH($bits(lvl_ent_t)), .DEPTH(MAX_LEVELS)) u_lvl_ram (
        .aclk  (aclk),
        .we    (lvl_we),
        .waddr (lvl_wa),
        .wdata (lvl_wd),
        .raddr (cnt_reg[LAW-1:0]),
        .rdata (lvl_rd)
    );

    assign is_oscan  = (cmd.step == STEP_OSCAN);
    assign is_lscan  = (cmd.step == STEP_LSCAN);
    assign lim       = is_oscan ? CW'(MAX_ORDERS) : CW'(MAX_LEVELS);
    assign iss       = (cnt_reg != lim);
    assign last      = rv_reg && (ri_reg == lim - CW'(1));
    assign same_mode = (kind_reg == KIND_MODIFY) && (price_reg == oprice_reg);

    assign o_match  = ord_rd.valid && (ord_rd.side == side_reg) && (ord_rd.ident == id_reg);
    assign o_empty  = !ord_rd.valid;
    assign lo_match = lvl_rd.valid && (lvl_rd.side == side_reg) && (lvl_rd.price == oprice_reg);
    assign ln_match = lvl_rd.valid && (lvl_rd.side == side_reg) && (lvl_rd.price == price_reg);
    assign l_empty  = !lvl_rd.valid;

    // order leaves its old level
    assign leave_tot   = sub_floor(lo_tot_reg, oamt_reg);
    assign leave_cnt   = (lo_cnt_reg == '0) ? '0 : lo_cnt_reg - COUNT_W'(1);
    assign leave_freed = (leave_cnt == '0);

    // order joins its new level, or the same level with a new quantity
    always_comb begin
        if (same_mode) begin
            base_tot = tot_reg;
            base_cnt = acc_cnt_reg;
            join_idx = lo_idx_reg;
        end else if (ln_hit_reg) begin
            base_tot = ln_tot_reg;
            base_cnt = ln_cnt_reg;
            join_idx = ln_idx_reg;
        end else begin
            base_tot = '0;
            base_cnt = '0;
            // a slot freed by the leave counts as free when it is the lowest
            join_idx = (rem_reg && !(lf_ok_reg && (lf_idx_reg < lo_idx_reg))) ?
                       lo_idx_reg : lf_idx_reg;
        end
        join_tot = add_sat(base_tot, qty_reg);
        if (same_mode || base_cnt == COUNT_MAX) begin
            join_cnt = base_cnt;
        end else begin
            join_cnt = base_cnt + COUNT_W'(1);
        end
    end

    always_comb begin
        ord_we = 1'b0;
        ord_wa = (kind_reg == KIND_INSERT) ? ofree_reg : oidx_reg;
        ord_wd = '0;
        if (cmd.step == STEP_CLEAR) begin
            ord_we = (cnt_reg < CW'(MAX_ORDERS));
            ord_wa = cnt_reg[OAW-1:0];
        end else if (cmd.step == STEP_ORDW) begin
            ord_we = 1'b1;
            if (kind_reg != KIND_CANCEL) begin
                ord_wd.valid  = 1'b1;
                ord_wd.side   = side_reg;
                ord_wd.ident  = id_reg;
                ord_wd.price  = price_reg;
                ord_wd.amount = qty_reg;
            end
        end
    end

    always_comb begin
        lvl_we = 1'b0;
        lvl_wa = join_idx;
        lvl_wd = '0;
        if (cmd.step == STEP_CLEAR) begin
            lvl_we = (cnt_reg < CW'(MAX_LEVELS));
            lvl_wa = cnt_reg[LAW-1:0];
        end else if (cmd.step == STEP_LEAVE && !same_mode) begin
            lvl_we = 1'b1;
            lvl_wa = lo_idx_reg;
            if (!leave_freed) begin
                lvl_wd.valid = 1'b1;
                lvl_wd.side  = side_reg;
                lvl_wd.price = oprice_reg;
                lvl_wd.total = leave_tot;
                lvl_wd.count = leave_cnt;
            end
        end else if (cmd.step == STEP_JOIN) begin
            lvl_we       = 1'b1;
            lvl_wd.valid = 1'b1;
            lvl_wd.side  = side_reg;
            lvl_wd.price = price_reg;
            lvl_wd.total = join_tot;
            lvl_wd.count = join_cnt;
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.o_hit      = ohit_reg;
    assign stat.o_free     = ofree_ok_reg;
    assign stat.lo_hit     = lo_hit_reg;
    assign stat.ln_hit     = ln_hit_reg;
    assign stat.lf_ok      = lf_ok_reg;
    assign stat.same_price = (price_reg == oprice_reg);
    assign stat.same_qty   = (qty_reg == oamt_reg);
    assign stat.lo_le1     = (lo_cnt_reg <= COUNT_W'(1));
    assign stat.scan_done  = last;
    assign stat.clr_done   = (cnt_reg == CW'(MAXN - 1));
    assign stat.out_free   = !out_vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            rv_reg       <= 1'b0;
            ohit_reg     <= 1'b0;
            ofree_ok_reg <= 1'b0;
            lo_hit_reg   <= 1'b0;
            ln_hit_reg   <= 1'b0;
            lf_ok_reg    <= 1'b0;
            rem_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            case (cmd.step)
                STEP_CLEAR: begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                STEP_LOAD: begin
                    kind_reg     <= in_kind;
                    id_reg       <= in_id;
                    side_reg     <= in_side;
                    price_reg    <= in_price;
                    qty_reg      <= in_qty;
                    cnt_reg      <= '0;
                    rv_reg       <= 1'b0;
                    ohit_reg     <= 1'b0;
                    ofree_ok_reg <= 1'b0;
                    rem_reg      <= 1'b0;
                end
                STEP_OSCAN: begin
                    if (iss) cnt_reg <= cnt_reg + CW'(1);
                    rv_reg <= iss;
                    ri_reg <= cnt_reg;
                    if (rv_reg) begin
                        if (o_match && !ohit_reg) begin
                            ohit_reg   <= 1'b1;
                            oidx_reg   <= ri_reg[OAW-1:0];
                            oprice_reg <= ord_rd.price;
                            oamt_reg   <= ord_rd.amount;
                        end
                        if (o_empty && !ofree_ok_reg) begin
                            ofree_ok_reg <= 1'b1;
                            ofree_reg    <= ri_reg[OAW-1:0];
                        end
                    end
                end
                STEP_LSTART: begin
                    cnt_reg    <= '0;
                    rv_reg     <= 1'b0;
                    lo_hit_reg <= 1'b0;
                    ln_hit_reg <= 1'b0;
                    lf_ok_reg  <= 1'b0;
                end
                STEP_LSCAN: begin
                    if (iss) cnt_reg <= cnt_reg + CW'(1);
                    rv_reg <= iss;
                    ri_reg <= cnt_reg;
                    if (rv_reg) begin
                        // old price match is only used for modify and cancel
                        if (lo_match && !lo_hit_reg) begin
                            lo_hit_reg <= 1'b1;
                            lo_idx_reg <= ri_reg[LAW-1:0];
                            lo_tot_reg <= lvl_rd.total;
                            lo_cnt_reg <= lvl_rd.count;
                        end
                        if (ln_match && !ln_hit_reg) begin
                            ln_hit_reg <= 1'b1;
                            ln_idx_reg <= ri_reg[LAW-1:0];
                            ln_tot_reg <= lvl_rd.total;
                            ln_cnt_reg <= lvl_rd.count;
                        end
                        if (l_empty && !lf_ok_reg) begin
                            lf_ok_reg  <= 1'b1;
                            lf_idx_reg <= ri_reg[LAW-1:0];
                        end
                    end
                end
                STEP_ORDW: begin
                    // default answer: the order's current level, later steps override
                    res_status_reg  <= ST_OK;
                    res_price_reg   <= oprice_reg;
                    res_total_reg   <= lo_hit_reg ? lo_tot_reg : '0;
                    res_orders_reg  <= lo_hit_reg ? lo_cnt_reg : '0;
                    res_removed_reg <= 1'b0;
                end
                STEP_LEAVE: begin
                    if (same_mode) begin
                        tot_reg     <= leave_tot;
                        acc_cnt_reg <= lo_cnt_reg;
                    end else begin
                        rem_reg         <= leave_freed;
                        res_status_reg  <= ST_OK;
                        res_price_reg   <= oprice_reg;
                        res_total_reg   <= leave_freed ? '0 : leave_tot;
                        res_orders_reg  <= leave_cnt;
                        res_removed_reg <= leave_freed;
                    end
                end
                STEP_JOIN: begin
                    res_status_reg  <= ST_OK;
                    res_price_reg   <= price_reg;
                    res_total_reg   <= join_tot;
                    res_orders_reg  <= join_cnt;
                    res_removed_reg <= rem_reg;
                end
                STEP_ERR: begin
                    res_status_reg  <= cmd.code;
                    res_price_reg   <= '0;
                    res_total_reg   <= '0;
                    res_orders_reg  <= '0;
                    res_removed_reg <= 1'b0;
                end
                default: begin
                end
            endcase

            if (cmd.step == STEP_OUT_LOAD) begin
                out_vld_reg     <= 1'b1;
                out_status_reg  <= res_status_reg;
                out_price_reg   <= res_price_reg;
                out_total_reg   <= res_total_reg;
                out_orders_reg  <= res_orders_reg;
                out_removed_reg <= res_removed_reg;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_vld_reg;
    assign out_status  = out_status_reg;
    assign out_price   = out_price_reg;
    assign out_total   = out_total_reg;
    assign out_orders  = out_orders_reg;
    assign out_removed = out_removed_reg;

endmodule

[hdl/order_book_price_levels.sv]
// channel | dir | tuser           | tdata
// s_      | in  | kind            | order_id, is_buy, order_price, order_qty
// m_      | out | status          | level_price, level_total, level_orders, level_removed
//
// one operation is a scan of the order memory and a scan of the level memory, one
// entry per cycle each, plus check, write back and result load; errors on the order
// scan skip the level scan
// after reset both memories are swept clear, with s_tready low
// the result sits in an output register, so the next beat is taken while it waits
module order_book_price_levels #(
    parameter int MAX_ORDERS = obpl_pkg::DEF_MAX_ORDERS,
    parameter int MAX_LEVELS = obpl_pkg::DEF_MAX_LEVELS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // order_id[31:0], is_buy[32], order_price[64:33],
                                   // order_qty[96:65], zero pad
    input  logic [1:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // level_price[31:0], level_total[79:32],
                                   // level_orders[90:80], level_removed[91], zero pad
    output logic [2:0]   m_tuser   // status
);

    import obpl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [PRICE_W-1:0] out_price;
    logic [TOTAL_W-1:0] out_total;
    logic [COUNT_W-1:0] out_orders;
    logic               out_removed;

    obpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    obpl_dp #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser),
        .in_id       (s_tdata[31:0]),
        .in_side     (s_tdata[32]),
        .in_price    (s_tdata[64:33]),
        .in_qty      (s_tdata[96:65]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_price   (out_price),
        .out_total   (out_total),
        .out_orders  (out_orders),
        .out_removed (out_removed)
    );

    assign m_tdata = {4'b0, out_removed, out_orders, out_total, out_price};

endmodule
